### hdl/edf_pkg.sv
// package of shared constants for the edf task scheduler
`default_nettype none
package edf_pkg;
    localparam int NumTasksDef  = 8;
    localparam int TimeWidthDef = 32;
    localparam logic ActLoad = 1'b0;
    localparam logic ActTick = 1'b1;
    localparam logic [1:0] EvNone     = 2'd0;
    localparam logic [1:0] EvStart    = 2'd1;
    localparam logic [1:0] EvResume   = 2'd2;
    localparam logic [1:0] EvContinue = 2'd3;
endpackage
`default_nettype wire

### hdl/edf_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
`default_nettype none
module edf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### hdl/edf_task_scheduler_unit.sv
// Earliest-deadline-first scheduler for periodic tasks. A load transaction
// writes one task entry and, if its job count is nonzero, releases its first
// job; a tick transaction drops jobs that reach their deadline, releases due
// jobs, runs the ready job with the nearest deadline (lowest id on a tie) for
// one unit and advances time. Task entries live in one synchronous RAM, one
// word per task. A load reads and then writes its entry; a tick makes one
// read-modify-write sweep over the RAM to resolve misses and releases while
// tracking the earliest deadline, then a read-modify-write of the winner.
// When the winner displaces a previous runner that still has work, a further
// read-modify-write marks it as preempted. The result sits in an output
// register, so the next transaction is taken while it waits; a finished
// transaction holds in its last state until that register is free.
`default_nettype none
module edf_task_scheduler_unit
    import edf_pkg::*;
#(
    parameter int NUM_TASKS  = NumTasksDef,
    parameter int TIME_WIDTH = TimeWidthDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_action,
    input  wire logic [2:0]  i_task_slot,
    input  wire logic [15:0] i_period_len,
    input  wire logic [15:0] i_work_len,
    input  wire logic [15:0] i_job_count,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_running_task,
    output logic             o_cpu_idle,
    output logic [1:0]       o_run_event,
    output logic             o_finished_valid,
    output logic [7:0]       o_missed_mask,
    output logic [31:0]      o_missed_total,
    output logic [31:0]      o_released_total,
    output logic [31:0]      o_time_now
);
    localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int TW = TIME_WIDTH;
    // entry word: period, work, jobs, remaining, deadline, release, preempted
    localparam int EW = 16 * 4 + 2 * TW + 1;

    typedef struct packed {
        logic [15:0]   period;
        logic [15:0]   work;
        logic [15:0]   jobs;
        logic [15:0]   rem;
        logic [TW-1:0] dl;
        logic [TW-1:0] rel;
        logic          pre;
    } t_entry;

    localparam logic [3:0] StIdle  = 4'd0;
    localparam logic [3:0] StLoadR = 4'd1;
    localparam logic [3:0] StLoadW = 4'd2;
    localparam logic [3:0] StSweep = 4'd3;
    localparam logic [3:0] StRunR  = 4'd4;
    localparam logic [3:0] StRunW  = 4'd5;
    localparam logic [3:0] StOut   = 4'd6;
    localparam logic [3:0] StPreR  = 4'd7;
    localparam logic [3:0] StPreW  = 4'd8;

    logic [3:0]      r_state;
    logic [2:0]      r_slot;
    logic [15:0]     r_per, r_wrk, r_cnt;
    logic [IW:0]     r_idx;       // sweep counter, holds NUM_TASKS
    logic            r_ph;        // 0 read issued, 1 data back
    logic [TW-1:0]   r_tick;
    logic [IW:0]     r_last;      // top bit set means no runner
    logic [31:0]     r_miss, r_relc;
    logic [NUM_TASKS-1:0] r_live; // entry written since reset
    logic [NUM_TASKS-1:0] r_mask;
    logic            r_bvalid;
    logic [IW-1:0]   r_best;
    logic [TW-1:0]   r_bdist;
    logic            r_lastrem;   // last runner still has work after sweep
    logic [IW-1:0]   r_pidx;      // entry to mark as preempted
    logic [2:0]      r_otask;     // staged result fields
    logic            r_oidle;
    logic [1:0]      r_oev;
    logic            r_ofin;

    logic            we;
    logic [IW-1:0]   waddr, raddr;
    t_entry          wdata, rdata_raw, rd;

    edf_ram #(.WIDTH(EW), .DEPTH(NUM_TASKS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata_raw)
    );

    // entries never written read as reset value for dynamic fields
    logic [IW-1:0] cur;
    assign cur = (r_state == StSweep) ? r_idx[IW-1:0] :
                 (r_state inside {StRunR, StRunW}) ? r_best :
                 (r_state inside {StPreR, StPreW}) ? r_pidx : IW'(r_slot);
    always_comb begin
        rd = rdata_raw;
        if (!r_live[cur]) begin
            rd.jobs = '0;
            rd.rem  = '0;
            rd.dl   = '0;
            rd.rel  = '0;
            rd.pre  = 1'b0;
        end
    end

    logic slot_ok;
    assign slot_ok = ({{(32-3){1'b0}}, r_slot} < NUM_TASKS);

    // sweep entry update: miss then release
    t_entry sw;
    logic   sw_miss, sw_rel;
    logic [TW-1:0] sw_dist;
    always_comb begin
        sw = rd;
        sw_miss = (rd.rem != 16'd0) && (rd.dl == r_tick);
        sw_rel  = (rd.jobs != 16'd0) && (rd.rel == r_tick);
        if (sw_miss) begin
            sw.rem = '0;
            sw.pre = 1'b0;
        end
        if (sw_rel) begin
            sw.rem  = rd.work;
            sw.dl   = r_tick + TW'(rd.period);
            sw.rel  = r_tick + TW'(rd.period);
            sw.pre  = 1'b0;
            sw.jobs = rd.jobs - 16'd1;
        end
        sw_dist = sw.dl - r_tick;
    end

    // load entry update
    t_entry ld;
    always_comb begin
        ld = rd;
        ld.period = r_per;
        ld.work   = r_wrk;
        ld.jobs   = r_cnt;
        ld.rem    = '0;
        ld.pre    = 1'b0;
        if (r_cnt != 16'd0) begin
            ld.rem  = r_wrk;
            ld.dl   = r_tick + TW'(r_per);
            ld.rel  = r_tick + TW'(r_per);
            ld.jobs = r_cnt - 16'd1;
        end
    end

    // winner update
    t_entry rn;
    logic [1:0] rn_ev;
    always_comb begin
        rn = rd;
        if (rd.rem == rd.work) begin
            rn_ev = EvStart;
        end else if (rd.pre) begin
            rn_ev = EvResume;
        end else begin
            rn_ev = EvContinue;
        end
        rn.pre = 1'b0;
        rn.rem = rd.rem - 16'd1;
    end

    // displaced runner gets its preempted flag set
    t_entry pm;
    always_comb begin
        pm = rd;
        pm.pre = 1'b1;
    end

    // preempted flag of the previous runner is set in a second write
    logic prev_pre;
    assign prev_pre = !r_last[IW] && (r_last[IW-1:0] != r_best) && r_lastrem;

    assign o_ready = (r_state == StIdle);

    always_comb begin
        we = 1'b0;
        waddr = cur;
        wdata = sw;
        raddr = cur;
        if (r_state == StLoadW) begin
            we = slot_ok;
            wdata = ld;
        end else if (r_state == StSweep && r_ph) begin
            we = 1'b1;
            wdata = sw;
        end else if (r_state == StRunW) begin
            we = 1'b1;
            wdata = rn;
        end else if (r_state == StPreW) begin
            we = 1'b1;
            wdata = pm;
        end
    end

    logic [31:0] miss_inc;
    assign miss_inc = (r_miss == 32'hFFFF_FFFF) ? r_miss : r_miss + 32'd1;

    logic out_free;
    assign out_free = !o_valid || i_ready;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= StIdle;
            r_tick   <= '0;
            r_last   <= {1'b1, {IW{1'b0}}};
            r_miss   <= '0;
            r_relc   <= '0;
            r_live   <= '0;
            o_valid  <= 1'b0;
            r_idx    <= '0;
            r_ph     <= 1'b0;
            r_bvalid <= 1'b0;
        end else begin
            // result register handshake
            if (r_state == StOut && out_free) begin
                o_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                StIdle: begin
                    if (i_valid && o_ready) begin
                        r_slot <= i_task_slot;
                        r_per  <= i_period_len;
                        r_wrk  <= i_work_len;
                        r_cnt  <= i_job_count;
                        r_mask <= '0;
                        r_idx  <= '0;
                        r_ph   <= 1'b0;
                        r_bvalid  <= 1'b0;
                        r_lastrem <= 1'b0;
                        r_state <= (i_action == ActLoad) ? StLoadR : StSweep;
                    end
                end
                StLoadR: r_state <= StLoadW;
                StLoadW: begin
                    if (slot_ok) begin
                        r_live[cur] <= 1'b1;
                        if (r_last == {1'b0, cur}) begin
                            r_last <= {1'b1, {IW{1'b0}}};
                        end
                        if (r_cnt != 16'd0 && r_relc != 32'hFFFF_FFFF) begin
                            r_relc <= r_relc + 32'd1;
                        end
                    end
                    r_otask <= '0;
                    r_oidle <= 1'b1;
                    r_oev   <= EvNone;
                    r_ofin  <= 1'b0;
                    r_state <= StOut;
                end
                StSweep: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_live[r_idx[IW-1:0]] <= 1'b1;
                        if (sw_miss) begin
                            r_mask[r_idx[IW-1:0]] <= 1'b1;
                            r_miss <= miss_inc;
                            if (r_last == {1'b0, r_idx[IW-1:0]}) begin
                                r_last <= {1'b1, {IW{1'b0}}};
                            end
                        end
                        if (sw_rel && r_relc != 32'hFFFF_FFFF) begin
                            r_relc <= r_relc + 32'd1;
                        end
                        if (r_last == {1'b0, r_idx[IW-1:0]}) begin
                            r_lastrem <= (sw.rem != 16'd0);
                        end
                        if (sw.rem != 16'd0 && (!r_bvalid || sw_dist < r_bdist)) begin
                            r_bvalid <= 1'b1;
                            r_best   <= r_idx[IW-1:0];
                            r_bdist  <= sw_dist;
                        end
                        r_idx <= r_idx + (IW+1)'(1);
                        if (r_idx == (IW+1)'(NUM_TASKS - 1)) begin
                            r_state <= StRunR;
                        end
                    end
                end
                StRunR: begin
                    if (r_bvalid) begin
                        r_state <= StRunW;
                    end else begin
                        r_otask <= '0;
                        r_oidle <= 1'b1;
                        r_oev   <= EvNone;
                        r_ofin  <= 1'b0;
                        r_tick  <= r_tick + TW'(1);
                        r_state <= StOut;
                    end
                end
                StRunW: begin
                    r_otask <= 3'(r_best);
                    r_oidle <= 1'b0;
                    r_oev   <= rn_ev;
                    r_ofin  <= (rn.rem == 16'd0);
                    r_last <= (rn.rem == 16'd0) ? {1'b1, {IW{1'b0}}} : {1'b0, r_best};
                    r_tick <= r_tick + TW'(1);
                    if (prev_pre) begin
                        r_pidx  <= r_last[IW-1:0];
                        r_state <= StPreR;
                    end else begin
                        r_state <= StOut;
                    end
                end
                StPreR: r_state <= StPreW;
                StPreW: r_state <= StOut;
                StOut: begin
                    if (out_free) begin
                        o_running_task   <= r_otask;
                        o_cpu_idle       <= r_oidle;
                        o_run_event      <= r_oev;
                        o_finished_valid <= r_ofin;
                        o_missed_mask    <= 8'(r_mask);
                        o_missed_total   <= r_miss;
                        o_released_total <= r_relc;
                        o_time_now       <= 32'(r_tick);
                        r_state <= StIdle;
                    end
                end
                default: r_state <= StIdle;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != StIdle |-> !o_ready) else $error("accept while busy");
    a_idle_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_cpu_idle |-> o_run_event == EvNone) else $error("idle with event");
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_time_now)) else $error("result changed");
`endif
endmodule
`default_nettype wire

### bench/edf_task_scheduler_unit_tb.sv
// testbench for the edf task scheduler: directed table, then random load/tick traffic
`timescale 1ns / 100ps
module edf_task_scheduler_unit_tb
    import edf_pkg::*;
();

    localparam int NTASK       = 8;
    localparam int RAND_ITEMS  = 650;
    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 400;

    typedef struct packed {
        logic [2:0]  running_task;
        logic        cpu_idle;
        logic [1:0]  run_event;
        logic        finished_valid;
        logic [7:0]  missed_mask;
        logic [31:0] missed_total;
        logic [31:0] released_total;
        logic [31:0] time_now;
    } sched_res_t;

    typedef struct {
        logic        action;
        logic [2:0]  slot;
        logic [15:0] period;
        logic [15:0] work;
        logic [15:0] jobs;
        bit          typed;
        sched_res_t  res;
    } stim_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_action;
    logic [2:0]  i_task_slot;
    logic [15:0] i_period_len;
    logic [15:0] i_work_len;
    logic [15:0] i_job_count;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_running_task;
    logic        o_cpu_idle;
    logic [1:0]  o_run_event;
    logic        o_finished_valid;
    logic [7:0]  o_missed_mask;
    logic [31:0] o_missed_total;
    logic [31:0] o_released_total;
    logic [31:0] o_time_now;

    edf_task_scheduler_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_action(i_action), .i_task_slot(i_task_slot),
        .i_period_len(i_period_len), .i_work_len(i_work_len),
        .i_job_count(i_job_count),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_running_task(o_running_task), .o_cpu_idle(o_cpu_idle),
        .o_run_event(o_run_event), .o_finished_valid(o_finished_valid),
        .o_missed_mask(o_missed_mask), .o_missed_total(o_missed_total),
        .o_released_total(o_released_total), .o_time_now(o_time_now)
    );

    // scheduler shadow state
    logic [15:0] sh_period [NTASK];
    logic [15:0] sh_work   [NTASK];
    logic [15:0] sh_jobs   [NTASK];
    logic [15:0] sh_rem    [NTASK];
    logic [31:0] sh_dl     [NTASK];
    logic [31:0] sh_nrel   [NTASK];
    bit          sh_pre    [NTASK];
    logic [31:0] sh_tick;
    int          sh_last;
    logic [31:0] sh_misses;
    logic [31:0] sh_releases;

    sched_res_t pending_q[$];
    int  mismatches = 0;
    int  results_seen = 0;
    int  loads_sent = 0;
    int  ticks_sent = 0;
    int  quiet_cycles = 0;
    bit  calm = 0;
    bit  hold_req = 0;
    bit  sending_done = 0;

    function automatic logic [31:0] sat_add1(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    task automatic release_job(int t);
        logic [31:0] due;
        due = sh_tick + {16'd0, sh_period[t]};
        sh_rem[t]  = sh_work[t];
        sh_dl[t]   = due;
        sh_nrel[t] = due;
        sh_pre[t]  = 0;
        sh_jobs[t] = sh_jobs[t] - 16'd1;
        sh_releases = sat_add1(sh_releases);
    endtask

    task automatic sched_reset();
        for (int t = 0; t < NTASK; t++) begin
            sh_period[t] = '0; sh_work[t] = '0; sh_jobs[t] = '0; sh_rem[t] = '0;
            sh_dl[t] = '0; sh_nrel[t] = '0; sh_pre[t] = 0;
        end
        sh_tick = '0; sh_last = -1; sh_misses = '0; sh_releases = '0;
    endtask

    // one transaction through the scheduler shadow
    task automatic sched_predict(input logic act, input logic [2:0] slot,
                                 input logic [15:0] per, input logic [15:0] wrk,
                                 input logic [15:0] jc, output sched_res_t r);
        int best;
        logic [31:0] best_dist;
        logic [31:0] cur_dist;
        int s;
        r = '0;
        r.cpu_idle = 1'b1;
        if (act == ActLoad) begin
            s = slot;
            sh_period[s] = per; sh_work[s] = wrk; sh_jobs[s] = jc;
            sh_rem[s] = '0; sh_pre[s] = 0;
            if (sh_last == s) sh_last = -1;
            if (jc != 0) release_job(s);
        end else begin
            best = -1;
            best_dist = '0;
            // deadline misses
            for (int t = 0; t < NTASK; t++) begin
                if (sh_rem[t] != 0 && sh_dl[t] == sh_tick) begin
                    sh_rem[t] = '0; sh_pre[t] = 0;
                    if (sh_last == t) sh_last = -1;
                    r.missed_mask[t] = 1'b1;
                    sh_misses = sat_add1(sh_misses);
                end
            end
            // releases
            for (int t = 0; t < NTASK; t++)
                if (sh_jobs[t] != 0 && sh_nrel[t] == sh_tick) release_job(t);
            // earliest deadline, lowest id on a tie
            for (int t = 0; t < NTASK; t++) begin
                if (sh_rem[t] != 0) begin
                    cur_dist = sh_dl[t] - sh_tick;
                    if (best < 0 || cur_dist < best_dist) begin
                        best = t; best_dist = cur_dist;
                    end
                end
            end
            if (best >= 0) begin
                if (sh_last >= 0 && sh_last != best && sh_rem[sh_last] != 0)
                    sh_pre[sh_last] = 1;
                if (sh_rem[best] == sh_work[best]) r.run_event = EvStart;
                else if (sh_pre[best]) r.run_event = EvResume;
                else r.run_event = EvContinue;
                sh_pre[best] = 0;
                sh_rem[best] = sh_rem[best] - 16'd1;
                r.running_task = best[2:0];
                r.cpu_idle = 1'b0;
                sh_last = best;
                if (sh_rem[best] == 0) begin
                    r.finished_valid = 1'b1;
                    sh_last = -1;
                end
            end
            sh_tick = sh_tick + 32'd1;
        end
        r.missed_total   = sh_misses;
        r.released_total = sh_releases;
        r.time_now       = sh_tick;
    endtask

    task automatic report_mismatch(input string what, input sched_res_t got,
                                   input sched_res_t want);
        mismatches++;
        $write("MISMATCH %s: got run=%0d idle=%0b ev=%0d fin=%0b miss=%02h mt=%0d rt=%0d t=%0d",
               what, got.running_task, got.cpu_idle, got.run_event, got.finished_valid,
               got.missed_mask, got.missed_total, got.released_total, got.time_now);
        $display(" / want run=%0d idle=%0b ev=%0d fin=%0b miss=%02h mt=%0d rt=%0d t=%0d",
                 want.running_task, want.cpu_idle, want.run_event, want.finished_valid,
                 want.missed_mask, want.missed_total, want.released_total, want.time_now);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 70) return $urandom_range(0, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // send one transaction and record its expected result
    task automatic send_item(input logic act, input logic [2:0] slot,
                             input logic [15:0] per, input logic [15:0] wrk,
                             input logic [15:0] jc, input bit typed,
                             input sched_res_t typed_res);
        int gap;
        sched_res_t r;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act; i_task_slot <= slot;
        i_period_len <= per; i_work_len <= wrk; i_job_count <= jc;
        do @(posedge i_clk); while (!o_ready);
        sched_predict(act, slot, per, wrk, jc, r);
        pending_q.push_back(typed ? typed_res : r);
        if (act == ActLoad) loads_sent++; else ticks_sent++;
    endtask

    // stimulus
    initial begin
        stim_row_t rows[$];
        stim_row_t row;
        int burst;
        logic [2:0] slot;
        logic [15:0] per;
        logic [15:0] wrk;
        logic [15:0] jc;
        sched_res_t none_res;

        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_action <= ActTick; i_task_slot <= '0;
        i_period_len <= '0; i_work_len <= '0; i_job_count <= '0;
        sched_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        none_res = '0;
        // directed table: idle tick after reset, then the extremes typed in
        row = '{ActTick, 3'd0, 16'd0, 16'd0, 16'd0, 1, '0};
        row.res.cpu_idle = 1'b1; row.res.time_now = 32'd1;
        rows.push_back(row);
        row = '{ActLoad, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, '0};
        row.res.cpu_idle = 1'b1; row.res.released_total = 32'd1; row.res.time_now = 32'd1;
        rows.push_back(row);
        rows.push_back('{ActTick, 3'd0, 16'd0, 16'd0, 16'd0, 0, none_res});
        // zero period: misses at the next tick and is re-released in that tick
        rows.push_back('{ActLoad, 3'd0, 16'd0, 16'd1, 16'd2, 0, none_res});
        rows.push_back('{ActTick, 3'd0, 16'd0, 16'd0, 16'd0, 0, none_res});
        rows.push_back('{ActTick, 3'd0, 16'd0, 16'd0, 16'd0, 0, none_res});
        // zero work and zero job count
        rows.push_back('{ActLoad, 3'd1, 16'd4, 16'd0, 16'd1, 0, none_res});
        rows.push_back('{ActLoad, 3'd2, 16'd9, 16'd3, 16'd0, 0, none_res});
        rows.push_back('{ActLoad, 3'd3, 16'd6, 16'd4, 16'd3, 0, none_res});
        rows.push_back('{ActTick, 3'd0, 16'd0, 16'd0, 16'd0, 0, none_res});
        // reload of a busy task
        rows.push_back('{ActLoad, 3'd3, 16'd8, 16'd4, 16'd2, 0, none_res});
        rows.push_back('{ActTick, 3'd0, 16'd0, 16'd0, 16'd0, 0, none_res});
        rows.push_back('{ActTick, 3'd0, 16'd0, 16'd0, 16'd0, 0, none_res});
        // shorter deadline preempts, then the preempted job resumes
        rows.push_back('{ActLoad, 3'd4, 16'd2, 16'd1, 16'd3, 0, none_res});
        for (int k = 0; k < 8; k++)
            rows.push_back('{ActTick, 3'd0, 16'd0, 16'd0, 16'd0, 0, none_res});
        rows.push_back('{ActLoad, 3'd7, 16'd1, 16'd0, 16'd0, 0, none_res});
        rows.push_back('{ActTick, 3'd0, 16'd0, 16'd0, 16'd0, 0, none_res});

        foreach (rows[k])
            send_item(rows[k].action, rows[k].slot, rows[k].period, rows[k].work,
                      rows[k].jobs, rows[k].typed, rows[k].res);

        // random traffic: mostly small periodic task sets and runs of ticks
        for (int n = 0; n < RAND_ITEMS; n++) begin
            calm = (n >= 400 && n < 480);
            if (n == 200) hold_req = 1;
            if ($urandom_range(0, 99) < 22) begin
                slot = 3'($urandom_range(0, 7));
                if ($urandom_range(0, 99) < 8) begin
                    per = 16'($urandom); wrk = 16'($urandom); jc = 16'($urandom);
                end else begin
                    per = 16'($urandom_range(0, 24));
                    wrk = 16'($urandom_range(0, 32'(per) + 2));
                    jc  = ($urandom_range(0, 9) == 0) ? 16'd0 :
                          16'($urandom_range(1, 30));
                end
                send_item(ActLoad, slot, per, wrk, jc, 0, none_res);
            end else begin
                burst = $urandom_range(0, 3);
                send_item(ActTick, 3'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 0, none_res);
                for (int b = 0; b < burst && n < RAND_ITEMS - 1; b++) begin
                    n++;
                    send_item(ActTick, 3'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 0, none_res);
                end
            end
        end
        i_valid <= 1'b0;
        sending_done = 1;
    end

    // receiver readiness, with one long hold-off while the sender keeps going
    initial begin
        int stall_left;
        stall_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (calm || $urandom_range(0, 7) != 0) begin
                i_ready <= 1'b1;
            end else begin
                stall_left = pick_gap();
                i_ready <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        sched_res_t got;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_running_task, o_cpu_idle, o_run_event, o_finished_valid,
                    o_missed_mask, o_missed_total, o_released_total, o_time_now};
            results_seen++;
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result", got, '0);
            end else if (got != pending_q[0]) begin
                report_mismatch("result", got, pending_q.pop_front());
            end else begin
                void'(pending_q.pop_front());
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // drain and final verdict
    initial begin
        wait (sending_done);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("covered %0d loads and %0d ticks, %0d results checked", loads_sent,
                 ticks_sent, results_seen);
        $display("jobs released %0d, deadlines missed %0d, final tick %0d", sh_releases,
                 sh_misses, sh_tick);
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

### edf_task_scheduler_unit.f
hdl/edf_pkg.sv
hdl/edf_ram.sv
hdl/edf_task_scheduler_unit.sv
bench/edf_task_scheduler_unit_tb.sv
